@@ rtl/wmpt_pkg.sv @@
// shared constants, types and state codes for the windowed modular power table
package wmpt_pkg;

   localparam int BASE        = 4;
   localparam int LOG_ELL     = 4;
   localparam int NUM_ROWS    = BASE - 1;
   localparam int MAX_RESULTS = 64;
   localparam int TOTAL       = (NUM_ROWS * LOG_ELL > MAX_RESULTS) ?
                                MAX_RESULTS : NUM_ROWS * LOG_ELL;
   localparam int MOD_W       = 31;
   localparam int VAL_W       = 32;
   localparam int BOUND_W     = 16;
   localparam int IDX_W       = 4;
   localparam int CNT_W       = 6;
   localparam int STEP_W      = 5;
   localparam int CSR_IDX_W   = 2;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_MODULUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOUND   = 2'd1;

   // command into the shared modular multiplier
   typedef struct packed {
      logic             start;
      logic [MOD_W-1:0] a;
      logic [VAL_W-1:0] b;
   } mm_cmd_type;

   // answer from the shared modular multiplier
   typedef struct packed {
      logic             done;
      logic [MOD_W-1:0] product;
   } mm_rsp_type;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_RBAS = 8'b0000_0010,
      ST_RVAL = 8'b0000_0100,
      ST_TEST = 8'b0000_1000,
      ST_STEP = 8'b0001_0000,
      ST_PMUL = 8'b0010_0000,
      ST_PSQR = 8'b0100_0000,
      ST_OUT  = 8'b1000_0000
   } state_type;

endpackage

@@ rtl/wmpt_mulmod.sv @@
// bit-serial modular multiplier: a * b mod m, one bit of b per cycle
module wmpt_mulmod import wmpt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [MOD_W-1:0] modulus,
   input  mm_cmd_type       cmd,
   output mm_rsp_type       rsp
);

   logic [MOD_W-1:0]  acc_ff, acc_in;
   logic [MOD_W-1:0]  a_ff, a_in;
   logic [VAL_W-1:0]  b_ff, b_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [MOD_W:0]    dbl;
   logic [MOD_W-1:0]  dbl_red;
   logic [MOD_W:0]    sum;
   logic [MOD_W-1:0]  sum_red;

   // one step: double, reduce, add, reduce
   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, modulus}) ? MOD_W'(dbl - {1'b0, modulus}) : dbl[MOD_W-1:0];
      sum     = {1'b0, dbl_red} + (b_ff[VAL_W-1] ? {1'b0, a_ff} : '0);
      sum_red = (sum >= {1'b0, modulus}) ? MOD_W'(sum - {1'b0, modulus}) : sum[MOD_W-1:0];
   end

   // sequencing of the 32 steps
   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         acc_in  = '0;
         a_in    = cmd.a;
         b_in    = cmd.b;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = sum_red;
         b_in    = {b_ff[VAL_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(VAL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

   // a new command only lands on an idle unit
   assert property (@(posedge clock) disable iff (reset) cmd.start |-> !busy_ff)
      else $error("mulmod started while busy");

   // the result is reduced whenever the modulus is usable
   assert property (@(posedge clock) disable iff (reset)
                    (done_ff && modulus > MOD_W'(1)) |-> acc_ff < modulus)
      else $error("mulmod result not reduced");

   // done follows the final step
   assert property (@(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff))
      else $error("mulmod done without work");

endmodule

@@ rtl/windowed_modular_power_table.sv @@
// top level: sequencer, configuration registers and result register around the multiplier
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | req_value
//  rsp     | out       | rsp_valid / rsp_ready  | rsp_row rsp_column rsp_power rsp_present rsp_last
//  csr     | in        | csr_valid / csr_ready  | csr_index csr_data
//
// every modular product goes through the one bit-serial multiplier
// with a modulus above 1, a request costs two reductions; each entry but a row's first adds a
// column product and, when present with a nonzero residue, a squaring per exponent bit and a
// multiply per one bit (exponent < 2^16); one request at a time: req_ready is high only between tables
// a stalled result holds the sequencer; csr writes are taken every cycle
// synchronous active-high reset restores the default modulus and bound
module windowed_modular_power_table import wmpt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [VAL_W-1:0]     req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [IDX_W-1:0]     rsp_row,
   output logic [IDX_W-1:0]     rsp_column,
   output logic [MOD_W-1:0]     rsp_power,
   output logic                 rsp_present,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VAL_W-1:0]     csr_data
);

   state_type          state_ff, state_in;
   logic [MOD_W-1:0]   modulus_ff;
   logic [BOUND_W-1:0] bound_ff;
   logic [MOD_W-1:0]   base_r_ff, base_r_in;
   logic [MOD_W-1:0]   yb_ff, yb_in;
   logic [VAL_W-1:0]   y_ff, y_in;
   logic [MOD_W-1:0]   bpw_ff, bpw_in;
   logic [MOD_W-1:0]   acc_ff, acc_in;
   logic [MOD_W-1:0]   pb_ff, pb_in;
   logic [BOUND_W-1:0] e_ff, e_in;
   logic [IDX_W-1:0]   row_ff, row_in;
   logic [IDX_W-1:0]   col_ff, col_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [MOD_W-1:0]   power_ff, power_in;
   logic               present_ff, present_in;
   logic               last_ff, last_in;
   logic [IDX_W-1:0]   orow_ff, orow_in;
   logic [IDX_W-1:0]   ocol_ff, ocol_in;
   mm_cmd_type         mm_cmd;
   mm_rsp_type         mm_rsp;
   logic               mzero;
   logic [MOD_W-1:0]   bp;
   logic [MOD_W+IDX_W:0] e_full;
   logic [VAL_W-1:0]   e32;
   logic [VAL_W-1:0]   em1;
   logic               ok;

   wmpt_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .modulus (modulus_ff),
      .cmd     (mm_cmd),
      .rsp     (mm_rsp)
   );

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MOD_W'(536903681);
         bound_ff   <= BOUND_W'(16);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MODULUS: modulus_ff <= csr_data[MOD_W-1:0];
            REG_BOUND:   bound_ff   <= csr_data[BOUND_W-1:0];
            default: ;
         endcase
      end
   end

   // exponent for the current entry and its bound test
   always_comb begin
      mzero  = (modulus_ff <= MOD_W'(1));
      bp     = (base_r_ff == '0) ? '0 : bpw_ff;
      e_full = ({{(MOD_W-IDX_W){1'b0}}, 1'b0, row_ff} + 1'b1) * {1'b0, bp};
      e32    = e_full[VAL_W-1:0];
      em1    = e32 - 1'b1;
      ok     = em1 < {{(VAL_W-BOUND_W){1'b0}}, bound_ff};
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      base_r_in    = base_r_ff;
      yb_in        = yb_ff;
      y_in         = y_ff;
      bpw_in       = bpw_ff;
      acc_in       = acc_ff;
      pb_in        = pb_ff;
      e_in         = e_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      power_in     = power_ff;
      present_in   = present_ff;
      last_in      = last_ff;
      orow_in      = orow_ff;
      ocol_in      = ocol_ff;
      mm_cmd.start = 1'b0;
      mm_cmd.a     = MOD_W'(1);
      mm_cmd.b     = VAL_W'(BASE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               y_in   = req_value;
               row_in = '0;
               col_in = '0;
               cnt_in = '0;
               bpw_in = MOD_W'(1);
               if (mzero) begin
                  base_r_in = '0;
                  yb_in     = '0;
                  state_in  = ST_TEST;
               end else begin
                  mm_cmd.start = 1'b1;
                  state_in     = ST_RBAS;
               end
            end
         end
         ST_RBAS: begin
            if (mm_rsp.done) begin
               base_r_in    = mm_rsp.product;
               mm_cmd.start = 1'b1;
               mm_cmd.b     = y_ff;
               state_in     = ST_RVAL;
            end
         end
         ST_RVAL: begin
            if (mm_rsp.done) begin
               yb_in    = mm_rsp.product;
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            orow_in    = row_ff;
            ocol_in    = col_ff;
            last_in    = (cnt_ff == CNT_W'(TOTAL - 1));
            present_in = ok;
            acc_in     = MOD_W'(1);
            pb_in      = yb_ff;
            e_in       = e32[BOUND_W-1:0];
            if (ok && yb_ff != '0) begin
               state_in = ST_STEP;
            end else begin
               power_in     = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_STEP: begin
            if (e_ff == '0) begin
               power_in     = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end else begin
               mm_cmd.start = 1'b1;
               mm_cmd.a     = e_ff[0] ? acc_ff : pb_ff;
               mm_cmd.b     = {{(VAL_W-MOD_W){1'b0}}, pb_ff};
               state_in     = e_ff[0] ? ST_PMUL : ST_PSQR;
            end
         end
         ST_PMUL: begin
            if (mm_rsp.done) begin
               acc_in       = mm_rsp.product;
               mm_cmd.start = 1'b1;
               mm_cmd.a     = pb_ff;
               mm_cmd.b     = {{(VAL_W-MOD_W){1'b0}}, pb_ff};
               state_in     = ST_PSQR;
            end
         end
         ST_PSQR: begin
            if (mm_rsp.done) begin
               pb_in    = mm_rsp.product;
               e_in     = e_ff >> 1;
               state_in = ST_STEP;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               cnt_in       = cnt_ff + 1'b1;
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else if (col_ff == IDX_W'(LOG_ELL - 1)) begin
                  col_in   = '0;
                  row_in   = row_ff + 1'b1;
                  bpw_in   = MOD_W'(1);
                  state_in = ST_TEST;
               end else begin
                  col_in = col_ff + 1'b1;
                  if (mzero) begin
                     state_in = ST_TEST;
                  end else begin
                     // next power of the base for the following column
                     mm_cmd.start = 1'b1;
                     mm_cmd.a     = bpw_ff;
                     mm_cmd.b     = {{(VAL_W-MOD_W){1'b0}}, base_r_ff};
                     state_in     = ST_RVAL;
                     yb_in        = yb_ff;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // column product shares the wait state with the value reduction
      if (state_ff == ST_RVAL && mm_rsp.done && cnt_ff != '0) begin
         yb_in  = yb_ff;
         bpw_in = mm_rsp.product;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_r_ff  <= base_r_in;
      yb_ff      <= yb_in;
      y_ff       <= y_in;
      bpw_ff     <= bpw_in;
      acc_ff     <= acc_in;
      pb_ff      <= pb_in;
      e_ff       <= e_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      cnt_ff     <= cnt_in;
      power_ff   <= power_in;
      present_ff <= present_in;
      last_ff    <= last_in;
      orow_ff    <= orow_in;
      ocol_ff    <= ocol_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_row     = orow_ff;
   assign rsp_column  = ocol_ff;
   assign rsp_power   = power_ff;
   assign rsp_present = present_ff;
   assign rsp_last    = last_ff;

   // a result is shown only while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff |-> state_ff == ST_OUT)
      else $error("result valid outside output wait");

   // an accepted request closes the input until the table is done
   assert property (@(posedge clock) disable iff (reset) (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // an absent entry always reads zero
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && !present_ff) |-> power_ff == '0)
      else $error("absent entry with nonzero power");

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the windowed modular power table
module testbench import wmpt_pkg::*; ();

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] column;
      logic [MOD_W-1:0] power;
      logic             present;
      logic             last;
   } entry_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [VAL_W-1:0]     req_value;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [IDX_W-1:0]     rsp_row;
   logic [IDX_W-1:0]     rsp_column;
   logic [MOD_W-1:0]     rsp_power;
   logic                 rsp_present;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [VAL_W-1:0]     csr_data;

   logic [VAL_W-1:0] pending_values[$];
   entry_type        expected_entries[$];
   logic [31:0]      cur_modulus;
   logic [31:0]      cur_bound;
   logic             req_taken;
   int               sender_idle_pct;
   int               receiver_idle_pct;
   logic             long_hold_go;
   logic             long_hold_done;
   int               hold_left;
   int               mismatches = 0;
   int               values_taken = 0;
   int               entries_checked = 0;
   int               csr_writes;

   windowed_modular_power_table u_top (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // x^e mod m with the zero residue rule
   function automatic logic [31:0] pow_mod(longint unsigned x, logic [31:0] e,
                                           logic [31:0] m);
      longint unsigned acc;
      longint unsigned b;
      acc = 1;
      if (m == 0) return 0;
      b = x % m;
      if (b == 0) return 0;
      while (e > 0) begin
         if (e[0]) acc = (acc * b) % m;
         e = e >> 1;
         b = (b * b) % m;
      end
      return 32'(acc % m);
   endfunction

   // queue the whole power table for one request value
   task automatic predict_table(logic [VAL_W-1:0] y);
      entry_type   ent;
      logic [31:0] bp;
      logic [31:0] e;
      int          n;
      n = 0;
      for (int i = 0; i < NUM_ROWS; i++) begin
         for (int j = 0; j < LOG_ELL; j++) begin
            if (n < TOTAL) begin
               bp = pow_mod(BASE, j, cur_modulus);
               e = 32'((i + 1) * longint'(bp));
               ent.row = IDX_W'(i);
               ent.column = IDX_W'(j);
               ent.present = (e - 32'd1) < cur_bound;
               ent.power = ent.present ? MOD_W'(pow_mod(y, e, cur_modulus)) : '0;
               ent.last = (n == TOTAL - 1);
               expected_entries = {expected_entries, ent};
               n++;
            end
         end
      end
   endtask

   task automatic flag_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_value <= '0;
      end else if (!req_valid || req_taken) begin
         if (pending_values.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_value <= pending_values.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver, with one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         long_hold_done <= 1'b0;
      end else if (long_hold_go && !long_hold_done) begin
         long_hold_done <= 1'b1;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // monitor: predict on accepted requests, check accepted results, track register writes
   always @(posedge clock) begin
      entry_type exp_ent;
      if (reset) begin
         req_taken <= 1'b0;
         cur_modulus <= 32'd536903681;
         cur_bound <= 32'd16;
      end else begin
         req_taken <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_MODULUS) cur_modulus <= {1'b0, csr_data[MOD_W-1:0]};
            else if (csr_index == REG_BOUND) cur_bound <= {16'd0, csr_data[BOUND_W-1:0]};
         end
         if (req_valid && req_ready) begin
            predict_table(req_value);
            values_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_entries.size() == 0) begin
               flag_mismatch("result with nothing expected");
            end else begin
               exp_ent = expected_entries.pop_front();
               entries_checked++;
               if (rsp_row !== exp_ent.row || rsp_column !== exp_ent.column ||
                   rsp_power !== exp_ent.power || rsp_present !== exp_ent.present ||
                   rsp_last !== exp_ent.last)
                  flag_mismatch($sformatf(
                     "got r%0d c%0d p%0d pr%0b l%0b, want r%0d c%0d p%0d pr%0b l%0b",
                     rsp_row, rsp_column, rsp_power, rsp_present, rsp_last,
                     exp_ent.row, exp_ent.column, exp_ent.power, exp_ent.present,
                     exp_ent.last));
            end
         end
      end
   end

   // register write through the csr channel
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   task automatic wait_drained();
      while (pending_values.size() > 0 || req_valid || expected_entries.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // new register setting, then a batch of random values
   task automatic run_phase(logic [30:0] m, logic [15:0] bound, int count);
      wait_drained();
      write_csr(REG_MODULUS, {1'($urandom_range(1)), m});
      write_csr(REG_BOUND, {16'($urandom), bound});
      for (int k = 0; k < count; k++) pending_values = {pending_values, $urandom};
   endtask

   // stimulus sequence
   initial begin
      csr_writes = 0;
      long_hold_go = 1'b0;
      sender_idle_pct = 13;
      receiver_idle_pct = 69;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed values under the reset setting: extremes and zero residues
      pending_values = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'd536903681, 32'd1073807362, 32'd536903680,
                         32'hAAAA_AAAA, 32'h5555_5555};
      // long receiver hold while the sender keeps offering
      long_hold_go = 1'b1;

      run_phase(31'h7FFF_FFFF, 16'hFFFF, 20);
      run_phase(31'd0, 16'd7, 6);
      run_phase(31'd1, 16'hFFFF, 6);
      sender_idle_pct = 69;
      receiver_idle_pct = 13;
      run_phase(31'd2, 16'd0, 6);
      run_phase(31'd7, 16'hFFFF, 16);
      run_phase(31'd17, 16'd300, 16);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      run_phase(31'd536903681, 16'd16, 28);
      wait_drained();

      $display("covered %0d values, %0d table entries, %0d register writes",
               values_taken, entries_checked, csr_writes);
      if (mismatches == 0 && expected_entries.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // run limit
   initial begin
      #200000000;
      $display("tb: failure");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/wmpt_pkg.sv
rtl/wmpt_mulmod.sv
rtl/windowed_modular_power_table.sv
tb/testbench.sv
